// File: hw/rtl/udrf_pkg.sv
// udrf_pkg: shared types, codes and the recolor filter function for the
// UTF-8 decoder with recolor filter. No dependencies.

package udrf_pkg;

   localparam int CODE_W = 21;
   localparam int BYTE_W = 8;
   localparam int MODE_W = 2;
   localparam int PEND_W = 2;

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECOLOR_ENABLE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMAND_CHAR   = 1'b1;
   localparam int CSR_DATA_W = CODE_W;
   localparam logic [CODE_W-1:0] COMMAND_CHAR_RESET = 21'd35;

   // command filter modes
   localparam logic [MODE_W-1:0] MODE_WAIT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PAR  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_IN   = 2'd2;

   localparam logic [CODE_W-1:0] SPACE_CHAR = 21'h20;

   // lead and continuation byte classes
   localparam logic [BYTE_W-1:0] ASCII_MASK   = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_MASK   = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_TAG    = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK   = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_TAG    = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK   = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_TAG    = 8'hF0;
   localparam logic [BYTE_W-1:0] CONT_MASK    = 8'hC0;
   localparam logic [BYTE_W-1:0] CONT_TAG     = 8'h80;
   localparam logic [BYTE_W-1:0] PAYLOAD_MASK = 8'h3F;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [CODE_W-1:0] code_point;
      logic              invalid;
      logic              hidden;
      logic              last_of_run;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

   typedef struct packed {
      logic              recolor_enable;
      logic [CODE_W-1:0] command_char;
   } cfg_type;

   typedef struct packed {
      logic [PEND_W-1:0] bytes_pending;
      logic [CODE_W-1:0] partial_code;
      logic [MODE_W-1:0] command_mode;
   } dec_state_type;

   typedef struct packed {
      push_type      push;
      dec_state_type state;
   } step_type;

   typedef struct packed {
      logic              hide;
      logic [MODE_W-1:0] mode;
   } filt_type;

   // one letter through the three-state command filter
   function automatic filt_type recolor_filter(logic [MODE_W-1:0] mode,
                                               logic [CODE_W-1:0] c,
                                               logic [CODE_W-1:0] cmd);
      filt_type r;
      r.hide = 1'b0;
      r.mode = mode;
      if (c == cmd) begin
         case (mode)
            MODE_WAIT: begin
               r.mode = MODE_PAR;
               r.hide = 1'b1;
            end
            MODE_PAR: begin
               r.mode = MODE_WAIT;
            end
            MODE_IN: begin
               r.mode = MODE_WAIT;
               r.hide = 1'b1;
            end
            default: begin
               r.mode = mode;
            end
         endcase
      end
      if (r.mode == MODE_PAR) begin
         if (c == SPACE_CHAR) r.mode = MODE_IN;
         r.hide = 1'b1;
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/udrf_if.sv
// udrf_if: valid/ready channel interfaces for the byte and result words.
// Depends on udrf_pkg for field widths.

interface udrf_req_if;
   logic                         valid;
   logic                         ready;
   logic [udrf_pkg::BYTE_W-1:0]  byte_in;
   logic                         end_of_text;

   modport source (output valid, output byte_in, output end_of_text, input ready);
   modport sink   (input valid, input byte_in, input end_of_text, output ready);
endinterface

interface udrf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [udrf_pkg::CODE_W-1:0]  code_point;
   logic                         invalid;
   logic                         hidden;
   logic                         last_of_run;

   modport source (output valid, output code_point, output invalid, output hidden,
                   output last_of_run, input ready);
   modport sink   (input valid, input code_point, input invalid, input hidden,
                   input last_of_run, output ready);
endinterface

// File: hw/rtl/udrf_step.sv
// udrf_step: combinational decode of one byte word plus the recolor filter.
// Gives up to two result words and the next decoder state. Uses udrf_pkg.

module udrf_step (
   input  logic [udrf_pkg::BYTE_W-1:0] byte_in,
   input  logic                        end_of_text,
   input  udrf_pkg::dec_state_type     state,
   input  udrf_pkg::cfg_type           cfg,
   output udrf_pkg::step_type          step
);

   logic                        e1_valid;
   logic                        e1_bad;
   logic [udrf_pkg::CODE_W-1:0] e1_code;
   logic                        e2_valid;
   logic                        e2_bad;
   logic [udrf_pkg::CODE_W-1:0] e2_code;
   logic                        lead_en;
   logic [3:0]                  shift;
   logic [udrf_pkg::CODE_W-1:0] merged;
   logic [udrf_pkg::PEND_W-1:0] pend_next;
   logic [udrf_pkg::CODE_W-1:0] part_next;
   logic [udrf_pkg::MODE_W-1:0] mode_mid;
   logic [udrf_pkg::MODE_W-1:0] mode_end;
   udrf_pkg::filt_type          f1;
   udrf_pkg::filt_type          f2;
   udrf_pkg::rsp_item_type      item_a;
   udrf_pkg::rsp_item_type      item_b;

   // continuation payload lands 6 bits lower for each byte already taken
   always_comb begin
      case (state.bytes_pending)
         2'd3:    shift = 4'd12;
         2'd2:    shift = 4'd6;
         default: shift = 4'd0;
      endcase
      merged = state.partial_code
             | (udrf_pkg::CODE_W'(byte_in & udrf_pkg::PAYLOAD_MASK) << shift);
   end

   always_comb begin
      e1_valid  = 1'b0;
      e1_bad    = 1'b0;
      e1_code   = '0;
      e2_valid  = 1'b0;
      e2_bad    = 1'b0;
      e2_code   = '0;
      lead_en   = 1'b0;
      pend_next = state.bytes_pending;
      part_next = state.partial_code;

      if (end_of_text) begin
         e1_valid  = (state.bytes_pending != '0);
         e1_bad    = 1'b1;
         pend_next = '0;
         part_next = '0;
      end else if (state.bytes_pending != '0) begin
         if ((byte_in & udrf_pkg::CONT_MASK) == udrf_pkg::CONT_TAG) begin
            pend_next = state.bytes_pending - 2'd1;
            if (state.bytes_pending == 2'd1) begin
               e1_valid  = 1'b1;
               e1_code   = merged;
               part_next = '0;
            end else begin
               part_next = merged;
            end
         end else begin
            // broken sequence: flag it, then treat the byte as a new lead
            e1_valid = 1'b1;
            e1_bad   = 1'b1;
            lead_en  = 1'b1;
         end
      end else begin
         lead_en = 1'b1;
      end

      if (lead_en) begin
         pend_next = '0;
         part_next = '0;
         if ((byte_in & udrf_pkg::ASCII_MASK) == '0) begin
            e2_valid = 1'b1;
            e2_code  = udrf_pkg::CODE_W'(byte_in);
         end else if ((byte_in & udrf_pkg::LEAD2_MASK) == udrf_pkg::LEAD2_TAG) begin
            part_next = {10'd0, byte_in[4:0], 6'd0};
            pend_next = 2'd1;
         end else if ((byte_in & udrf_pkg::LEAD3_MASK) == udrf_pkg::LEAD3_TAG) begin
            part_next = {5'd0, byte_in[3:0], 12'd0};
            pend_next = 2'd2;
         end else if ((byte_in & udrf_pkg::LEAD4_MASK) == udrf_pkg::LEAD4_TAG) begin
            part_next = {byte_in[2:0], 18'd0};
            pend_next = 2'd3;
         end else begin
            e2_valid = 1'b1;
            e2_bad   = 1'b1;
         end
      end
   end

   // filter runs over the two letters in order
   always_comb begin
      f1       = udrf_pkg::recolor_filter(state.command_mode, e1_code, cfg.command_char);
      mode_mid = (cfg.recolor_enable && e1_valid) ? f1.mode : state.command_mode;
      f2       = udrf_pkg::recolor_filter(mode_mid, e2_code, cfg.command_char);
      mode_end = (cfg.recolor_enable && e2_valid) ? f2.mode : mode_mid;

      item_a.code_point  = e1_code;
      item_a.invalid     = e1_bad;
      item_a.hidden      = cfg.recolor_enable & f1.hide;
      item_a.last_of_run = ~e2_valid;
      item_b.code_point  = e2_code;
      item_b.invalid     = e2_bad;
      item_b.hidden      = cfg.recolor_enable & f2.hide;
      item_b.last_of_run = 1'b1;

      if (e1_valid) begin
         step.push.count = e2_valid ? 2'd2 : 2'd1;
         step.push.item0 = item_a;
         step.push.item1 = item_b;
      end else begin
         step.push.count = e2_valid ? 2'd1 : 2'd0;
         step.push.item0 = item_b;
         step.push.item1 = item_b;
      end

      step.state.bytes_pending = pend_next;
      step.state.partial_code  = part_next;
      step.state.command_mode  = end_of_text ? udrf_pkg::MODE_WAIT : mode_end;
   end

endmodule

// File: hw/rtl/udrf_rsp_queue.sv
// udrf_rsp_queue: small flop-based result queue, up to two words pushed and
// one popped per cycle. Uses udrf_pkg for the result word type.

module udrf_rsp_queue #(
   parameter int DEPTH = udrf_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  udrf_pkg::push_type     push,
   input  logic                   pop,
   output logic                   room,
   output logic                   not_empty,
   output udrf_pkg::rsp_item_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   udrf_pkg::rsp_item_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] wr_next;

   function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign wr_next   = ptr_inc(wr_ptr_ff);
   assign room      = (count_ff <= CW'(DEPTH - 2));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      case (push.count)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = ptr_inc(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ptr_ff] <= push.item0;
      if (push.count == 2'd2) entry_ff[wr_next]   <= push.item1;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("result queue count beyond depth");

   a_no_double_push_full: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> room)
      else $error("two words pushed without room");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty result queue");

endmodule

// File: hw/rtl/utf8_decoder_with_recolor_filter_core.sv
// utf8_decoder_with_recolor_filter_core: top level of the UTF-8 decoder.
// Depends on udrf_pkg, udrf_if, udrf_step and udrf_rsp_queue.
//
// Usage:
//   req_ch carries one byte word per handshake (byte_in, end_of_text).
//   rsp_ch carries decoded code point words (code_point, invalid, hidden,
//   last_of_run); one byte word gives zero, one or two result words and
//   last_of_run marks the final word caused by that byte.
//   csr_* writes recolor_enable (index 0) and command_char (index 1); write
//   only while no byte word is in flight.
// Results: an accepted byte word writes its result words into the queue at
//   the accepting edge; if the queue was empty, the first shows right after.
// Throughput: one byte word per cycle while req_ch.ready is high; the decode
//   and filter are a single combinational pass from the req_ch word into the
//   state and result queue. A byte that yields two words needs a second rsp_ch
//   handshake, absorbed by the result queue (QUEUE_DEPTH words).
// Reset: synchronous; clears decoder state, filter mode, queue and the
//   configuration (filter off, command character '#').
// Stall: when rsp_ch stalls the queue fills; req_ch.ready drops once fewer
//   than two free entries remain, so no result word is ever dropped.

module utf8_decoder_with_recolor_filter_core #(
   parameter int QUEUE_DEPTH = udrf_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   udrf_req_if.sink                             req_ch,
   udrf_rsp_if.source                           rsp_ch,
   input  logic                                 csr_wr_en,
   input  logic [udrf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [udrf_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   udrf_pkg::cfg_type       cfg_ff, cfg_in;
   udrf_pkg::dec_state_type state_ff, state_in;
   udrf_pkg::step_type      step;
   udrf_pkg::push_type      push;
   udrf_pkg::rsp_item_type  head;
   logic                    room;
   logic                    not_empty;
   logic                    req_accept;
   logic                    rsp_pop;

   assign req_ch.ready = room;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign rsp_pop      = rsp_ch.valid && rsp_ch.ready;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            udrf_pkg::CSR_RECOLOR_ENABLE: cfg_in.recolor_enable = csr_wdata[0];
            udrf_pkg::CSR_COMMAND_CHAR:   cfg_in.command_char   = csr_wdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   // decode + filter of the word presented on req_ch
   udrf_step u_step (
      .byte_in     (req_ch.byte_in),
      .end_of_text (req_ch.end_of_text),
      .state       (state_ff),
      .cfg         (cfg_ff),
      .step        (step)
   );

   // state only moves on an accepted byte word
   always_comb begin
      state_in   = req_accept ? step.state : state_ff;
      push       = step.push;
      push.count = req_accept ? step.push.count : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.recolor_enable  <= 1'b0;
         cfg_ff.command_char    <= udrf_pkg::COMMAND_CHAR_RESET;
         state_ff.bytes_pending <= '0;
         state_ff.partial_code  <= '0;
         state_ff.command_mode  <= udrf_pkg::MODE_WAIT;
      end else begin
         cfg_ff   <= cfg_in;
         state_ff <= state_in;
      end
   end

   udrf_rsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_pop),
      .room      (room),
      .not_empty (not_empty),
      .head      (head)
   );

   assign rsp_ch.valid       = not_empty;
   assign rsp_ch.code_point  = head.code_point;
   assign rsp_ch.invalid     = head.invalid;
   assign rsp_ch.hidden      = head.hidden;
   assign rsp_ch.last_of_run = head.last_of_run;

   // no stale code bits linger once a sequence is closed
   a_idle_partial_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff.bytes_pending == '0) |-> (state_ff.partial_code == '0))
      else $error("partial code left over with nothing pending");

   // end marker always leaves the decoder and filter idle
   a_eot_idle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_ch.end_of_text) |=>
      (state_ff.bytes_pending == '0 && state_ff.command_mode == udrf_pkg::MODE_WAIT))
      else $error("end marker did not return decoder to idle");

   // mode value 3 is never entered
   a_mode_reachable: assert property (@(posedge clock) disable iff (reset)
      state_ff.command_mode != 2'd3)
      else $error("filter mode reached unused code");

endmodule

// File: test/utf8_decoder_with_recolor_filter_core_tb.sv
// Self-checking bench for utf8_decoder_with_recolor_filter_core: directed byte
// table, then random byte streams over several filter settings. Needs udrf_pkg,
// udrf_if and the core RTL.

module utf8_decoder_with_recolor_filter_core_tb;

   localparam int CLOCK_HALF    = 6;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 4;        // result shows right after the edge that takes its byte
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASES        = 8;
   localparam int PHASE_WORDS   = 180;
   localparam int SCRIPT_LEN    = 29;

   // where a table row takes its expected words from
   localparam logic FROM_MODEL = 1'b0;
   localparam logic BY_HAND    = 1'b1;

   typedef struct packed {
      logic                   filter;   // recolor_enable wanted while this byte goes in
      logic [7:0]             data;
      logic                   eot;
      logic                   src;
      logic [1:0]             n;        // hand-typed word count
      udrf_pkg::rsp_item_type e0;
      udrf_pkg::rsp_item_type e1;
   } script_row_type;

   localparam udrf_pkg::rsp_item_type NO_LETTER = '0;
   localparam udrf_pkg::rsp_item_type BAD_LAST  = '{21'd0, 1'b1, 1'b0, 1'b1};

   // Directed part: byte extremes, bad leads, stray continuation, broken and
   // flushed sequences, overlong-free max code, surrogate, then the command
   // filter walking through all three modes and an end marker mid-command.
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      '{1'b0, 8'h00, 1'b0, BY_HAND,    2'd1, '{21'h0, 1'b0, 1'b0, 1'b1}, NO_LETTER},
      '{1'b0, 8'h7F, 1'b0, BY_HAND,    2'd1, '{21'h7F, 1'b0, 1'b0, 1'b1}, NO_LETTER},
      '{1'b0, 8'h80, 1'b0, BY_HAND,    2'd1, BAD_LAST, NO_LETTER},   // stray cont
      '{1'b0, 8'hF8, 1'b0, BY_HAND,    2'd1, BAD_LAST, NO_LETTER},   // bad lead
      '{1'b0, 8'hFF, 1'b1, BY_HAND,    2'd0, NO_LETTER, NO_LETTER},  // idle eot
      '{1'b0, 8'hC3, 1'b0, FROM_MODEL, 2'd0, NO_LETTER, NO_LETTER},
      '{1'b0, 8'hA9, 1'b0, FROM_MODEL, 2'd0, NO_LETTER, NO_LETTER},
      '{1'b0, 8'hF7, 1'b0, FROM_MODEL, 2'd0, NO_LETTER, NO_LETTER},
      '{1'b0, 8'hBF, 1'b0, FROM_MODEL, 2'd0, NO_LETTER, NO_LETTER},
      '{1'b0, 8'hBF, 1'b0, FROM_MODEL, 2'd0, NO_LETTER, NO_LETTER},
      '{1'b0, 8'hBF, 1'b0, BY_HAND,    2'd1, '{21'h1FFFFF, 1'b0, 1'b0, 1'b1}, NO_LETTER},
      '{1'b0, 8'hC2, 1'b0, FROM_MODEL, 2'd0, NO_LETTER, NO_LETTER},
      // bad continuation: broken sequence, then 'A' decoded afresh
      '{1'b0, 8'h41, 1'b0, BY_HAND,    2'd2, '{21'h0, 1'b1, 1'b0, 1'b0},
                                             '{21'h41, 1'b0, 1'b0, 1'b1}},
      '{1'b0, 8'hE0, 1'b0, FROM_MODEL, 2'd0, NO_LETTER, NO_LETTER},
      '{1'b0, 8'h00, 1'b1, BY_HAND,    2'd1, BAD_LAST, NO_LETTER},   // flush
      '{1'b0, 8'hED, 1'b0, FROM_MODEL, 2'd0, NO_LETTER, NO_LETTER},  // surrogate
      '{1'b0, 8'hA0, 1'b0, FROM_MODEL, 2'd0, NO_LETTER, NO_LETTER},
      '{1'b0, 8'h80, 1'b0, FROM_MODEL, 2'd0, NO_LETTER, NO_LETTER},
      '{1'b1, 8'h23, 1'b0, FROM_MODEL, 2'd0, NO_LETTER, NO_LETTER},  // "#F x#"
      '{1'b1, 8'h46, 1'b0, FROM_MODEL, 2'd0, NO_LETTER, NO_LETTER},
      '{1'b1, 8'h20, 1'b0, FROM_MODEL, 2'd0, NO_LETTER, NO_LETTER},
      '{1'b1, 8'h78, 1'b0, FROM_MODEL, 2'd0, NO_LETTER, NO_LETTER},
      '{1'b1, 8'h23, 1'b0, FROM_MODEL, 2'd0, NO_LETTER, NO_LETTER},
      '{1'b1, 8'h23, 1'b0, FROM_MODEL, 2'd0, NO_LETTER, NO_LETTER},  // "##" shows 2nd
      '{1'b1, 8'h23, 1'b0, FROM_MODEL, 2'd0, NO_LETTER, NO_LETTER},
      '{1'b1, 8'h23, 1'b0, FROM_MODEL, 2'd0, NO_LETTER, NO_LETTER},  // open again
      '{1'b1, 8'h00, 1'b1, FROM_MODEL, 2'd0, NO_LETTER, NO_LETTER},  // eot drops it
      '{1'b1, 8'h61, 1'b0, FROM_MODEL, 2'd0, NO_LETTER, NO_LETTER},
      '{1'b1, 8'hFF, 1'b0, FROM_MODEL, 2'd0, NO_LETTER, NO_LETTER}   // invalid, filtered
   };

   // random phases: filter setting and command character, extremes included
   localparam bit          PHASE_ON   [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1,
                                                   1'b1, 1'b1, 1'b0, 1'b1};
   localparam bit          PHASE_DRAW [PHASES] = '{1'b0, 1'b0, 1'b0, 1'b0,
                                                   1'b0, 1'b1, 1'b1, 1'b0};
   localparam logic [20:0] PHASE_CMD  [PHASES] = '{21'd35, 21'd0, 21'h1FFFFF,
                                                   21'h1FFFFF, 21'h20, 21'd0,
                                                   21'd0, 21'd35};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                             csr_wr_en;
   logic [udrf_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [udrf_pkg::CSR_DATA_W-1:0]  csr_wdata;

   udrf_req_if req_ch();
   udrf_rsp_if rsp_ch();

   utf8_decoder_with_recolor_filter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #CLOCK_HALF clock = ~clock;

   // decoder shadow: configuration and state as the core should hold them
   logic                        model_enable;
   logic [20:0]                 model_cmd;
   logic [1:0]                  model_pending;
   logic [20:0]                 model_partial;
   logic [udrf_pkg::MODE_W-1:0] model_mode;

   udrf_pkg::rsp_item_type step_res [2];    // words caused by the byte just taken
   int                     step_n;
   udrf_pkg::rsp_item_type expected_letters [$];

   bit            req_steady;      // no gaps on the byte side while set
   bit            rsp_steady;      // result side always ready while set
   int            words_sent;
   int            letters_seen;
   int            mismatches;
   int            cycle_count;

   // One decoded letter through the command filter. The filter only moves
   // when recolor is on; invalid letters go through it as code 0.
   function automatic void emit_letter(input logic [20:0] code, input logic bad);
      udrf_pkg::rsp_item_type r;
      logic                   hide;
      hide = 1'b0;
      if (model_enable) begin
         if (code == model_cmd) begin
            case (model_mode)
               udrf_pkg::MODE_WAIT: begin
                  model_mode = udrf_pkg::MODE_PAR;
                  hide = 1'b1;
               end
               udrf_pkg::MODE_PAR: begin
                  model_mode = udrf_pkg::MODE_WAIT;
               end
               udrf_pkg::MODE_IN: begin
                  model_mode = udrf_pkg::MODE_WAIT;
                  hide = 1'b1;
               end
               default: ;
            endcase
         end
         // the color parameter is hidden up to and including its space
         if (model_mode == udrf_pkg::MODE_PAR) begin
            if (code == udrf_pkg::SPACE_CHAR) model_mode = udrf_pkg::MODE_IN;
            hide = 1'b1;
         end
      end
      r.code_point  = code;
      r.invalid     = bad;
      r.hidden      = hide;
      r.last_of_run = 1'b0;
      step_res[step_n] = r;
      step_n++;
   endfunction

   function automatic void start_sequence(input logic [7:0] b);
      if ((b & udrf_pkg::ASCII_MASK) == 8'h00) begin
         emit_letter({13'd0, b}, 1'b0);
      end else if ((b & udrf_pkg::LEAD2_MASK) == udrf_pkg::LEAD2_TAG) begin
         model_partial = {10'd0, b[4:0], 6'd0};
         model_pending = 2'd1;
      end else if ((b & udrf_pkg::LEAD3_MASK) == udrf_pkg::LEAD3_TAG) begin
         model_partial = {5'd0, b[3:0], 12'd0};
         model_pending = 2'd2;
      end else if ((b & udrf_pkg::LEAD4_MASK) == udrf_pkg::LEAD4_TAG) begin
         model_partial = {b[2:0], 18'd0};
         model_pending = 2'd3;
      end else begin
         emit_letter(21'd0, 1'b1);
      end
   endfunction

   // Next state and result words for one accepted byte word.
   function automatic void decode_byte(input logic [7:0] b, input logic eot);
      step_n = 0;
      if (eot) begin
         if (model_pending != 2'd0) begin
            emit_letter(21'd0, 1'b1);
            model_pending = 2'd0;
            model_partial = 21'd0;
         end
         model_mode = udrf_pkg::MODE_WAIT;
      end else if (model_pending != 2'd0) begin
         if ((b & udrf_pkg::CONT_MASK) == udrf_pkg::CONT_TAG) begin
            model_partial = model_partial
                          | (21'(b[5:0]) << (6 * (int'(model_pending) - 1)));
            model_pending = model_pending - 2'd1;
            if (model_pending == 2'd0) begin
               emit_letter(model_partial, 1'b0);
               model_partial = 21'd0;
            end
         end else begin
            // broken sequence ends as invalid, this byte starts over
            emit_letter(21'd0, 1'b1);
            model_pending = 2'd0;
            model_partial = 21'd0;
            start_sequence(b);
         end
      end else begin
         start_sequence(b);
      end
      if (step_n > 0) step_res[step_n-1].last_of_run = 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [20:0] got,
                                  input logic [20:0] want);
      $display("mismatch at result word %0d: %s got %h expected %h",
               letters_seen, what, got, want);
      mismatches++;
   endtask

   task automatic check_letter();
      udrf_pkg::rsp_item_type want;
      letters_seen++;
      if (expected_letters.size() == 0) begin
         report_mismatch("unexpected word, code", rsp_ch.code_point, 21'd0);
      end else begin
         want = expected_letters.pop_front();
         if (rsp_ch.code_point !== want.code_point)
            report_mismatch("code_point", rsp_ch.code_point, want.code_point);
         if (rsp_ch.invalid !== want.invalid)
            report_mismatch("invalid", 21'(rsp_ch.invalid), 21'(want.invalid));
         if (rsp_ch.hidden !== want.hidden)
            report_mismatch("hidden", 21'(rsp_ch.hidden), 21'(want.hidden));
         if (rsp_ch.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", 21'(rsp_ch.last_of_run),
                            21'(want.last_of_run));
      end
   endtask

   // Drive one byte word, hold it until taken, then queue what it must give.
   // ready is sampled mid-cycle; nothing we drive moves before the next edge.
   task automatic send_word(input script_row_type w);
      int gap;
      bit took;
      gap = req_steady ? 0 : int'($urandom_range(0, 8));
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.byte_in     <= w.data;
      req_ch.end_of_text <= w.eot;
      do begin
         @(negedge clock);
         took = req_ch.ready;
         @(posedge clock);
      end while (!took);
      words_sent++;
      decode_byte(w.data, w.eot);
      if (w.src == BY_HAND) begin
         if (w.n > 2'd0) expected_letters.push_back(w.e0);
         if (w.n > 2'd1) expected_letters.push_back(w.e1);
      end else begin
         for (int i = 0; i < step_n; i++) expected_letters.push_back(step_res[i]);
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic eot);
      script_row_type w;
      w      = '0;
      w.data = b;
      w.eot  = eot;
      w.src  = FROM_MODEL;
      send_word(w);
   endtask

   // First 'keep' bytes of the n-byte form of v (n may be overlong).
   task automatic send_letter(input logic [20:0] v, input int n, input int keep);
      logic [7:0] b;
      for (int k = 0; k < keep; k++) begin
         if (n == 1) begin
            b = {1'b0, v[6:0]};
         end else if (k == 0) begin
            case (n)
               2:       b = udrf_pkg::LEAD2_TAG | {3'b000, v[10:6]};
               3:       b = udrf_pkg::LEAD3_TAG | {4'b0000, v[15:12]};
               default: b = udrf_pkg::LEAD4_TAG | {5'b00000, v[20:18]};
            endcase
         end else begin
            b = udrf_pkg::CONT_TAG | {2'b00, 6'(v >> (6 * (n - 1 - k)))};
         end
         send_byte(b, 1'b0);
      end
   endtask

   // Sender holds off until every queued word has come back, then lets the
   // core settle; used before register writes and as mid-stream back-off.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_letters.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [udrf_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [udrf_pkg::CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == udrf_pkg::CSR_RECOLOR_ENABLE) model_enable = value[0];
      else model_cmd = value;
      @(posedge clock);
   endtask

   // result side: random ready gaps per word, compared mid-cycle
   initial begin
      int gap;
      bit took;
      wait (reset == 1'b0);
      forever begin
         gap = rsp_steady ? 0 : int'($urandom_range(0, 8));
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         took = 1'b0;
         while (!took) begin
            @(negedge clock);
            if (rsp_ch.valid) begin
               check_letter();
               took = 1'b1;
            end
            @(posedge clock);
         end
      end
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [20:0] v;
      logic [20:0] cmd;
      int          pick;
      int          need;
      int          n;
      int          phase_end;

      req_ch.valid       <= 1'b0;
      req_ch.byte_in     <= 8'h00;
      req_ch.end_of_text <= 1'b0;
      rsp_ch.ready       <= 1'b0;
      csr_wr_en          <= 1'b0;
      csr_index          <= udrf_pkg::CSR_RECOLOR_ENABLE;
      csr_wdata          <= '0;
      words_sent   = 0;
      letters_seen = 0;
      mismatches   = 0;
      req_steady   = 1'b0;
      rsp_steady   = 1'b0;

      model_enable  = 1'b0;
      model_cmd     = udrf_pkg::COMMAND_CHAR_RESET;
      model_pending = 2'd0;
      model_partial = 21'd0;
      model_mode    = udrf_pkg::MODE_WAIT;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table; filter switches only with the core drained
      for (int i = 0; i < SCRIPT_LEN; i++) begin
         if (SCRIPT[i].filter != model_enable) begin
            wait_drained();
            write_csr(udrf_pkg::CSR_RECOLOR_ENABLE, 21'(SCRIPT[i].filter));
         end
         send_word(SCRIPT[i]);
      end

      // random phases
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         // upper data bits are don't-care for the enable register
         write_csr(udrf_pkg::CSR_RECOLOR_ENABLE, {20'($urandom), PHASE_ON[p]});
         cmd = PHASE_DRAW[p] ? 21'($urandom_range(0, 21'h1FFFFF) >> $urandom_range(0, 20))
                             : PHASE_CMD[p];
         write_csr(udrf_pkg::CSR_COMMAND_CHAR, cmd);
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         phase_end  = words_sent + PHASE_WORDS;

         while (words_sent < phase_end) begin
            if ($urandom_range(0, 39) == 0) req_steady = !req_steady;
            if ($urandom_range(0, 39) == 0) rsp_steady = !rsp_steady;
            if ($urandom_range(0, 149) == 0) wait_drained();

            // letter: the command char and space often, so the filter moves
            pick = int'($urandom_range(0, 99));
            if (pick < 25)      v = model_cmd;
            else if (pick < 40) v = udrf_pkg::SPACE_CHAR;
            else if (pick < 70) v = 21'($urandom_range(0, 127));
            else v = 21'($urandom_range(0, 21'h1FFFFF) >> $urandom_range(0, 20));
            need = (v < 21'h80) ? 1 : (v < 21'h800) ? 2 : (v < 21'h10000) ? 3 : 4;
            n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(need, 4)) : need;

            pick = int'($urandom_range(0, 99));
            if (pick < 85) begin
               send_letter(v, n, n);
            end else if (pick < 90) begin
               send_byte(8'($urandom_range(0, 255)), 1'b0);
            end else if (pick < 94) begin
               send_byte(8'($urandom_range(0, 255)), 1'b1);
            end else begin
               // cut-off sequence, then a random byte or end marker
               n = int'($urandom_range(2, 4));
               send_letter(v, n, int'($urandom_range(1, n - 1)));
               send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
         end
      end

      wait_drained();
      if (mismatches == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
